/* sv/stpm_pkg.sv */
// Shared types and codes for the sensor timestamp pair matcher.
`default_nettype none

package stpm_pkg;

    // tuser codes on the input stream
    localparam logic OP_SCANNER = 1'b0;
    localparam logic OP_CAMERA  = 1'b1;

    // tuser codes on the output stream
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } queue_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

/* sv/stpm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module stpm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/stpm_queue.sv */
// Circular timestamp queue: pointers and fill count around one RAM.
`default_nettype none

module stpm_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire stpm_pkg::queue_cmd_t  cmd,
    input  wire logic [WIDTH-1:0]      wr_data,
    output stpm_pkg::queue_status_t    status,
    output logic      [WIDTH-1:0]      rd_data
);

    import stpm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd.push && !cmd.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop && !cmd.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_COUNT);

    stpm_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

/* sv/sensor_timestamp_pair_matcher.sv */
// A dropped stamp (queue full) is reported from the push state once the output register is
// free; a match goes through the push, read and compare states, plus a read and a compare
// for every head discarded on the way. A new stamp is taken only in the idle state, once the
// last one is done; a stalled result word holds the sequencer.
// Reset (rst_n, async, active low) empties both queues and zeroes both previous times;
// queue RAM contents are not cleared and are only read after being written.
`default_nettype none

module sensor_timestamp_pair_matcher #(
    parameter int SCANNER_DEPTH = 16,
    parameter int CAMERA_DEPTH  = 32,
    parameter int TIME_WIDTH    = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // input stream
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [((TIME_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // stamp
    input  wire logic s_tuser,                                     // op
    // result stream
    output logic      m_tvalid,
    input  wire logic m_tready,
    // scanner_time, camera_time, offset, scanner_interval
    output logic      [((4 * TIME_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic      m_tuser                                      // kind
);

    import stpm_pkg::*;

    localparam int TW  = TIME_WIDTH;
    localparam int DW  = TIME_WIDTH + 1;
    localparam int OUTW = ((4 * TIME_WIDTH + 2 + 7) / 8) * 8;
    localparam int PADW = OUTW - (4 * TIME_WIDTH + 2);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a stamp
    localparam logic [1:0] ST_PUSH = 2'd1;  // store it or report the drop
    localparam logic [1:0] ST_READ = 2'd2;  // fetch both queue heads
    localparam logic [1:0] ST_CMP  = 2'd3;  // decide: pop camera, pop scanner or match

    logic [1:0] state_reg, state_next;

    // accepted word
    logic          op_reg, op_next;
    logic [TW-1:0] stamp_reg, stamp_next;

    // matcher history
    logic [TW-1:0] prev_cam_reg, prev_cam_next;
    logic [TW-1:0] prev_scan_reg, prev_scan_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [TW-1:0] scan_time_reg, scan_time_next;
    logic [TW-1:0] cam_time_reg, cam_time_next;
    logic [DW-1:0] offset_reg, offset_next;
    logic [DW-1:0] interval_reg, interval_next;

    queue_cmd_t    scan_cmd, cam_cmd;
    queue_status_t scan_status, cam_status;
    logic [TW-1:0] scan_head, cam_head;

    logic out_free;
    logic cam_below, scan_below;
    logic near_is_prev;
    logic [DW:0]   pair_sum;
    logic [DW:0]   twice_head;
    logic [DW-1:0] diff_prev, diff_cam;

    // The output register frees up in the same cycle its word is taken.
    assign out_free = !out_valid_reg || m_tready;

    // Compare the scanner head l against the previous camera time p and the camera head c.
    assign cam_below  = (prev_cam_reg < scan_head) && (cam_head < scan_head);
    assign scan_below = (prev_cam_reg > scan_head) && (cam_head > scan_head);

    // c - l > l - p, evaluated as c + p > 2l so nothing goes negative
    assign pair_sum     = {2'b00, cam_head} + {2'b00, prev_cam_reg};
    assign twice_head   = {1'b0, scan_head, 1'b0};
    assign near_is_prev = (pair_sum > twice_head);

    // Both candidate offsets in parallel; the compare only selects.
    assign diff_prev = {1'b0, scan_head} - {1'b0, prev_cam_reg};
    assign diff_cam  = {1'b0, scan_head} - {1'b0, cam_head};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        stamp_next     = stamp_reg;
        prev_cam_next  = prev_cam_reg;
        prev_scan_next = prev_scan_reg;
        kind_next      = kind_reg;
        scan_time_next = scan_time_reg;
        cam_time_next  = cam_time_reg;
        offset_next    = offset_reg;
        interval_next  = interval_reg;
        out_valid_next = out_valid_reg && !m_tready;
        scan_cmd       = '0;
        cam_cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    stamp_next = s_tdata[TW-1:0];
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if ((op_reg == OP_SCANNER) ? scan_status.full : cam_status.full)
                begin
                    // drop the stamp, report it once the output register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_DROP;
                        scan_time_next = '0;
                        cam_time_next  = '0;
                        offset_next    = '0;
                        interval_next  = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    scan_cmd.push = (op_reg == OP_SCANNER);
                    cam_cmd.push  = (op_reg == OP_CAMERA);
                    state_next    = ST_READ;
                end
            end

            ST_READ:
            begin
                if (!scan_status.empty && !cam_status.empty)
                begin
                    scan_cmd.rd = 1'b1;
                    cam_cmd.rd  = 1'b1;
                    state_next  = ST_CMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_CMP:
            begin
                if (cam_below)
                begin
                    // camera head is stale: advance the camera queue
                    cam_cmd.pop   = 1'b1;
                    prev_cam_next = cam_head;
                    state_next    = ST_READ;
                end
                else if (scan_below)
                begin
                    // scanner head precedes both camera times: drop it
                    scan_cmd.pop   = 1'b1;
                    prev_scan_next = scan_head;
                    state_next     = ST_READ;
                end
                else if (out_free)
                begin
                    // bracketed: emit the pair and pop both heads
                    out_valid_next = 1'b1;
                    kind_next      = KIND_MATCH;
                    scan_time_next = scan_head;
                    cam_time_next  = near_is_prev ? prev_cam_reg : cam_head;
                    offset_next    = near_is_prev ? diff_prev : diff_cam;
                    interval_next  = {1'b0, scan_head} - {1'b0, prev_scan_reg};
                    prev_cam_next  = cam_head;
                    prev_scan_next = scan_head;
                    scan_cmd.pop   = 1'b1;
                    cam_cmd.pop    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_cam_reg  <= '0;
            prev_scan_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_cam_reg  <= prev_cam_next;
            prev_scan_reg <= prev_scan_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        stamp_reg     <= stamp_next;
        kind_reg      <= kind_next;
        scan_time_reg <= scan_time_next;
        cam_time_reg  <= cam_time_next;
        offset_reg    <= offset_next;
        interval_reg  <= interval_next;
    end

    stpm_queue #(
        .WIDTH (TW),
        .DEPTH (SCANNER_DEPTH)
    ) u_scan_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (scan_cmd),
        .wr_data (stamp_reg),
        .status  (scan_status),
        .rd_data (scan_head)
    );

    stpm_queue #(
        .WIDTH (TW),
        .DEPTH (CAMERA_DEPTH)
    ) u_cam_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cam_cmd),
        .wr_data (stamp_reg),
        .status  (cam_status),
        .rd_data (cam_head)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{PADW{1'b0}}, interval_reg, offset_reg, cam_time_reg, scan_time_reg};

endmodule

`default_nettype wire
